// ===== sv/write_quorum_ack_tracker_macros.svh =====
// Assertion shorthands shared by the tracker modules.
// They expect clk and arst_n in the enclosing module.
`ifndef WRITE_QUORUM_ACK_TRACKER_MACROS_SVH
`define WRITE_QUORUM_ACK_TRACKER_MACROS_SVH

// same-cycle implication
`define WQAT_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define WQAT_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== sv/wqat_pkg.sv =====
package wqat_pkg;

	// table geometry
	localparam int MAX_SERVERS = 16;
	localparam int TAG_BITS    = 16;

	localparam int IDX_BITS = (MAX_SERVERS > 1) ? $clog2(MAX_SERVERS) : 1;
	localparam int CNT_BITS = $clog2(MAX_SERVERS + 1);

	// fixed field widths
	localparam int IN_TAG_BITS   = 16;
	localparam int CFG_BITS      = 5;
	localparam int CFG_IDX_BITS  = 1;
	localparam int OUT_CNT_BITS  = 5;
	localparam int OUT_DATA_BITS = 16;

	// signed compare width: covers total+1 and forward_count+1 minus quorum
	localparam int CMP_BITS = ((CNT_BITS > CFG_BITS) ? CNT_BITS : CFG_BITS) + 2;

	// register indexes
	localparam logic [CFG_IDX_BITS-1:0] REG_QUORUM  = 1'b0;
	localparam logic [CFG_IDX_BITS-1:0] REG_FORWARD = 1'b1;

	// reply codes
	localparam logic [1:0] REPLY_NONE = 2'd0;
	localparam logic [1:0] REPLY_ACK  = 2'd1;
	localparam logic [1:0] REPLY_NAK  = 2'd2;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DECIDE
	} state_t;

	typedef struct packed {
		logic [CFG_BITS-1:0] quorum_needed;
		logic [CFG_BITS-1:0] forward_count;
	} cfg_t;

	typedef struct packed {
		logic [1:0]              reply_kind;
		logic                    request_done;
		logic                    duplicate_seen;
		logic                    table_full;
		logic [OUT_CNT_BITS-1:0] answered_count;
		logic [OUT_CNT_BITS-1:0] success_count;
	} result_t;

endpackage

// ===== sv/wqat_tag_ram.sv =====
module wqat_tag_ram #(
	parameter int DEPTH = 16,
	parameter int WIDTH = 16,
	parameter int ADDR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic                 clk,
	input  logic                 wr_en,
	input  logic [ADDR_BITS-1:0] wr_addr,
	input  logic [WIDTH-1:0]     wr_data,
	input  logic                 rd_en,
	input  logic [ADDR_BITS-1:0] rd_addr,
	output logic [WIDTH-1:0]     rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// read data holds until the next read
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

// ===== sv/wqat_ctrl.sv =====
`include "write_quorum_ack_tracker_macros.svh"

module wqat_ctrl import wqat_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  cfg_t                   cfg,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  logic [IN_TAG_BITS-1:0] in_tag,
	input  logic                   in_kind,
	input  logic                   out_free,
	output logic                   res_valid,
	output result_t                res,
	output logic                   ram_rd_en,
	output logic [IDX_BITS-1:0]    ram_rd_addr,
	input  logic [TAG_BITS-1:0]    ram_rd_data,
	output logic                   ram_wr_en,
	output logic [IDX_BITS-1:0]    ram_wr_addr,
	output logic [TAG_BITS-1:0]    ram_wr_data
);

	state_t state_q, state_d;

	logic [TAG_BITS-1:0] tag_q;
	logic                kind_q;
	logic [IDX_BITS-1:0] rd_idx_q;
	logic                pend_q;
	logic                dup_q;
	logic [CNT_BITS-1:0] entries_q;
	logic [CNT_BITS-1:0] succ_q;
	logic                sent_q;

	logic                accept;
	logic                scan_last;
	logic                match;
	logic                dup;
	logic                full;
	logic                new_entry;
	logic [CNT_BITS-1:0] entries_n;
	logic [CNT_BITS-1:0] succ_n;
	logic [CMP_BITS-1:0] total_w;
	logic [CMP_BITS-1:0] succ_w;
	logic [CMP_BITS-1:0] fail_w;
	logic [CMP_BITS-1:0] svr_w;
	logic [CMP_BITS-1:0] quorum_w;
	logic [CMP_BITS-1:0] margin_w;
	logic                can_reply;
	logic                do_ack;
	logic                do_nak;
	logic                done;

	assign accept    = in_valid && in_ready;
	assign scan_last = (CNT_BITS'(rd_idx_q) + CNT_BITS'(1)) == entries_q;

	// hit on the entry read in the previous cycle
	assign match = pend_q && (ram_rd_data == tag_q);
	assign dup   = dup_q || match;

	assign full      = !dup && (entries_q >= CNT_BITS'(MAX_SERVERS));
	assign new_entry = !dup && !full;
	assign entries_n = entries_q + CNT_BITS'(new_entry);
	assign succ_n    = succ_q + CNT_BITS'(new_entry && !kind_q);

	// local server counts once as answered and as success
	assign total_w  = CMP_BITS'(entries_n) + CMP_BITS'(1);
	assign succ_w   = CMP_BITS'(succ_n) + CMP_BITS'(1);
	assign fail_w   = CMP_BITS'(entries_n) - CMP_BITS'(succ_n);
	assign svr_w    = CMP_BITS'(cfg.forward_count) + CMP_BITS'(1);
	assign quorum_w = CMP_BITS'(cfg.quorum_needed);
	assign margin_w = svr_w - quorum_w;

	assign can_reply = !sent_q && (cfg.quorum_needed != CFG_BITS'(1));
	assign do_ack    = can_reply && (succ_w >= quorum_w);
	assign do_nak    = can_reply && !do_ack && ($signed(fail_w) > $signed(margin_w));
	assign done      = total_w == svr_w;

	always_comb begin
		res.reply_kind     = do_ack ? REPLY_ACK : (do_nak ? REPLY_NAK : REPLY_NONE);
		res.request_done   = done;
		res.duplicate_seen = dup;
		res.table_full     = full;
		res.answered_count = total_w[OUT_CNT_BITS-1:0];
		res.success_count  = succ_w[OUT_CNT_BITS-1:0];
	end

	assign ram_rd_addr = rd_idx_q;
	assign ram_wr_en   = res_valid && new_entry;
	assign ram_wr_addr = entries_q[IDX_BITS-1:0];
	assign ram_wr_data = tag_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		in_ready  = 1'b0;
		ram_rd_en = 1'b0;
		res_valid = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					state_d = (entries_q == '0) ? ST_DECIDE : ST_SCAN;
				end
			end
			ST_SCAN: begin
				ram_rd_en = 1'b1;
				if (scan_last) begin
					state_d = ST_DECIDE;
				end
			end
			ST_DECIDE: begin
				if (out_free) begin
					res_valid = 1'b1;
					state_d   = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			tag_q  <= TAG_BITS'(in_tag);
			kind_q <= in_kind;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_idx_q  <= '0;
			pend_q    <= 1'b0;
			dup_q     <= 1'b0;
			entries_q <= '0;
			succ_q    <= '0;
			sent_q    <= 1'b0;
		end else begin
			if (accept) begin
				rd_idx_q <= '0;
				pend_q   <= 1'b0;
				dup_q    <= 1'b0;
			end else if (ram_rd_en) begin
				rd_idx_q <= rd_idx_q + IDX_BITS'(1);
				pend_q   <= 1'b1;
				dup_q    <= dup;
			end
			if (res_valid) begin
				entries_q <= done ? '0 : entries_n;
				succ_q    <= done ? '0 : succ_n;
				sent_q    <= done ? 1'b0 : (sent_q || do_ack || do_nak);
			end
		end
	end

	`WQAT_ASSERT_IMP(a_entries_bound, 1'b1, entries_q <= CNT_BITS'(MAX_SERVERS), "table count past depth")
	`WQAT_ASSERT_IMP(a_succ_le_entries, 1'b1, succ_q <= entries_q, "successes exceed entries")
	`WQAT_ASSERT_IMP(a_dup_full_excl, res_valid, !(dup && full), "duplicate and full together")
	`WQAT_ASSERT_NEXT(a_scan_start, accept && (entries_q != '0), state_q == ST_SCAN, "no scan after accept")
	`WQAT_ASSERT_NEXT(a_write_grows, ram_wr_en && !done, entries_q == $past(entries_q) + CNT_BITS'(1), "count did not grow")

endmodule

// ===== sv/write_quorum_ack_tracker.sv =====
// Channel  | Dir | Transfer content
// ---------+-----+-------------------------------------------------------------
// s_*      | in  | one replica response: server tag and success/failure kind
// m_*      | out | one result per response: reply, done, flags, counts
// cfg_*    | in  | register write: 0 quorum_needed, 1 forward_count
//
// Flow: a response passes from its transfer through the scan and decide steps to
// its result landing in the output register, and the next transfer is taken
// only back in the idle step, not while a response is in work; the tag table is
// searched one entry per cycle through the single read port of the table memory.
// Reset: arst_n clears counts, sent flag and output valid; the table memory is
// not cleared, since only entries below the fill count are ever read.
// Stalls: a new response is taken while a result waits on m_tready; the next
// result then holds in the decide step until the output register frees.
module write_quorum_ack_tracker import wqat_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_we,
	input  logic [CFG_IDX_BITS-1:0]  cfg_index,
	input  logic [CFG_BITS-1:0]      cfg_data,
	input  logic                     s_tvalid,
	output logic                     s_tready,
	input  logic [IN_TAG_BITS-1:0]   s_tdata,   // [15:0] server_tag
	input  logic [0:0]               s_tuser,   // [0] event_kind
	output logic                     m_tvalid,
	input  logic                     m_tready,
	// [1:0] reply_kind, [6:2] answered_count, [11:7] success_count, [15:12] zero
	output logic [OUT_DATA_BITS-1:0] m_tdata,
	output logic [1:0]               m_tuser,   // [0] duplicate_seen, [1] table_full
	output logic                     m_tlast    // request_done
);

	cfg_t    cfg_q;
	logic    out_valid_q;
	result_t out_q;

	logic                out_free;
	logic                res_valid;
	result_t             res;
	logic                ram_rd_en;
	logic [IDX_BITS-1:0] ram_rd_addr;
	logic [TAG_BITS-1:0] ram_rd_data;
	logic                ram_wr_en;
	logic [IDX_BITS-1:0] ram_wr_addr;
	logic [TAG_BITS-1:0] ram_wr_data;

	// configuration registers; read directly, so a write acts on the next result formed
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.quorum_needed <= CFG_BITS'(1);
			cfg_q.forward_count <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_QUORUM:  cfg_q.quorum_needed <= cfg_data;
				REG_FORWARD: cfg_q.forward_count <= cfg_data;
				default: ;
			endcase
		end
	end

	// output register: free when empty or drained this cycle
	assign out_free = !out_valid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_valid) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid) begin
			out_q <= res;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {{(OUT_DATA_BITS - 2 - 2*OUT_CNT_BITS){1'b0}},
			out_q.success_count, out_q.answered_count, out_q.reply_kind};
	assign m_tuser  = {out_q.table_full, out_q.duplicate_seen};
	assign m_tlast  = out_q.request_done;

	wqat_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg_q),
		.in_valid    (s_tvalid),
		.in_ready    (s_tready),
		.in_tag      (s_tdata),
		.in_kind     (s_tuser[0]),
		.out_free    (out_free),
		.res_valid   (res_valid),
		.res         (res),
		.ram_rd_en   (ram_rd_en),
		.ram_rd_addr (ram_rd_addr),
		.ram_rd_data (ram_rd_data),
		.ram_wr_en   (ram_wr_en),
		.ram_wr_addr (ram_wr_addr),
		.ram_wr_data (ram_wr_data)
	);

	// tag table: one write and one read port, registered read
	wqat_tag_ram #(
		.DEPTH     (MAX_SERVERS),
		.WIDTH     (TAG_BITS),
		.ADDR_BITS (IDX_BITS)
	) u_tag_ram (
		.clk     (clk),
		.wr_en   (ram_wr_en),
		.wr_addr (ram_wr_addr),
		.wr_data (ram_wr_data),
		.rd_en   (ram_rd_en),
		.rd_addr (ram_rd_addr),
		.rd_data (ram_rd_data)
	);

endmodule

// ===== tb/tb_top.sv =====
module tb_top;
	import wqat_pkg::*;

	logic clk;
	logic arst_n = 1'b0;

	// Register write port
	logic                    cfg_we    = 1'b0;
	logic [CFG_IDX_BITS-1:0] cfg_index = '0;
	logic [CFG_BITS-1:0]     cfg_data  = '0;

	// Response stream into the tracker
	logic                    s_tvalid = 1'b0;
	logic                    s_tready;
	logic [IN_TAG_BITS-1:0]  s_tdata  = '0;   // [15:0] server_tag
	logic [0:0]              s_tuser  = '0;   // [0] event_kind

	// Result stream out of the tracker
	logic                     m_tvalid;
	logic                     m_tready = 1'b0;
	logic [OUT_DATA_BITS-1:0] m_tdata;  // [1:0] reply_kind, [6:2] answered, [11:7] success
	logic [1:0]               m_tuser;  // [0] duplicate_seen, [1] table_full
	logic                     m_tlast;  // request_done

	write_quorum_ack_tracker dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast)
	);

	// ------------------------------------------------------------------
	// Shadow copy of the tracker: recorded tags, counts, sent flag and the
	// two registers. Only the tags matter for outputs, so per-entry
	// success bits are not kept; the held success count is enough.
	// ------------------------------------------------------------------
	logic [IN_TAG_BITS-1:0] rec_tags [MAX_SERVERS];
	int                     rec_count;
	int                     rec_succ;
	logic                   reply_done;
	logic [CFG_BITS-1:0]    quorum_reg;
	logic [CFG_BITS-1:0]    forward_reg;

	result_t pending_replies [$];   // expected results, oldest first

	// Run bookkeeping
	int  mismatches;
	int  sent_count, new_tag_count, cfg_writes, results_seen;
	int  n_ack, n_nak, n_done, n_dup, n_full, long_holds;
	bit  idle_on = 1'b1;            // random gaps on both sides
	int  hold_request;              // receiver picks this up as one long stall

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Hard stop in case a handshake never completes
	initial begin
		#40000000;
		$display("Mismatches found");
		$finish;
	end

	// Gap length: mostly none or short, a few long
	function automatic int pick_idle();
		int r;
		if (!idle_on)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 88)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	// Expected result for one accepted response; advances the shadow state.
	function automatic result_t track_response(logic [IN_TAG_BITS-1:0] tag, logic kind);
		result_t r;
		logic    hit;
		int      total, succ, fail, svr_total;
		r   = '0;
		hit = 1'b0;
		for (int i = 0; i < rec_count; i++)
			if (rec_tags[i] == tag)
				hit = 1'b1;
		if (hit) begin
			r.duplicate_seen = 1'b1;
		end else if (rec_count >= MAX_SERVERS) begin
			r.table_full = 1'b1;   // dropped, counts untouched
		end else begin
			rec_tags[rec_count] = tag;
			rec_count++;
			if (!kind)
				rec_succ++;
		end
		// local server counts as one answered success
		total     = rec_count + 1;
		succ      = rec_succ + 1;
		fail      = total - succ;
		svr_total = int'(forward_reg) + 1;
		// quorum of one: reply went out elsewhere; margin may go negative
		if (!reply_done && quorum_reg != 5'd1) begin
			if (succ >= int'(quorum_reg)) begin
				r.reply_kind = REPLY_ACK;
				reply_done   = 1'b1;
			end else if (fail > svr_total - int'(quorum_reg)) begin
				r.reply_kind = REPLY_NAK;
				reply_done   = 1'b1;
			end
		end
		r.answered_count = total[OUT_CNT_BITS-1:0];
		r.success_count  = succ[OUT_CNT_BITS-1:0];
		if (total == svr_total) begin
			r.request_done = 1'b1;
			rec_count      = 0;
			rec_succ       = 0;
			reply_done     = 1'b0;
		end
		return r;
	endfunction

	// A tag not currently recorded; corner values now and then
	function automatic logic [IN_TAG_BITS-1:0] fresh_tag();
		logic [IN_TAG_BITS-1:0] t;
		logic                   clash;
		do begin
			case ($urandom_range(0, 9))
				0: t = '0;
				1: t = '1;
				2: t = IN_TAG_BITS'($urandom_range(0, 31));
				default: t = IN_TAG_BITS'($urandom);
			endcase
			clash = 1'b0;
			for (int i = 0; i < rec_count; i++)
				if (rec_tags[i] == t)
					clash = 1'b1;
		end while (clash);
		return t;
	endfunction

	// One response transfer. valid only drops when a gap follows, so it
	// never gets two updates in the step of the previous transfer.
	task automatic send_response(input logic [IN_TAG_BITS-1:0] tag, input logic kind);
		int      gap;
		result_t want;
		gap = pick_idle();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= tag;
		s_tuser  <= kind;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		want = track_response(tag, kind);
		pending_replies.push_back(want);
		sent_count++;
		if (!want.duplicate_seen && !want.table_full)
			new_tag_count++;
	endtask

	// Sender goes quiet until every expected result has arrived
	task automatic drain_results();
		s_tvalid <= 1'b0;
		while (pending_replies.size() != 0) @(posedge clk);
	endtask

	// Registers change only with the tracker idle
	task automatic set_config(input logic [CFG_BITS-1:0] quorum, input logic [CFG_BITS-1:0] fwd);
		drain_results();
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= REG_QUORUM;
		cfg_data  <= quorum;
		@(posedge clk);
		cfg_index <= REG_FORWARD;
		cfg_data  <= fwd;
		@(posedge clk);
		cfg_we    <= 1'b0;
		quorum_reg  = quorum;
		forward_reg = fwd;
		cfg_writes += 2;
	endtask

	// Finish whatever request is open: make the expected server total equal
	// the current answered count, then repeat a recorded tag.
	task automatic close_request();
		if (rec_count == 0)
			return;
		set_config(quorum_reg, CFG_BITS'(rec_count));
		send_response(rec_tags[0], 1'($urandom_range(0, 1)));
	endtask

	// n_new fresh servers with random kinds, repeats sprinkled in
	task automatic run_request(input int n_new, input int dup_pct);
		for (int k = 0; k < n_new; k++) begin
			send_response(fresh_tag(), 1'($urandom_range(0, 1)));
			if (rec_count > 0 && $urandom_range(0, 99) < dup_pct)
				send_response(rec_tags[$urandom_range(0, rec_count - 1)],
					1'($urandom_range(0, 1)));
		end
	endtask

	// ------------------------------------------------------------------
	// Result side: random stalls, one long hold on request, and the check
	// of every transfer against the oldest expectation.
	// ------------------------------------------------------------------
	function automatic void compare_field(string name, int want, int got);
		if (want != got) begin
			$display("%0t: %s expected %0d actual %0d", $time, name, want, got);
			mismatches++;
		end
	endfunction

	task automatic check_result();
		result_t want;
		if (pending_replies.size() == 0) begin
			$display("%0t: result with nothing expected, expected none actual tdata %h tuser %b tlast %b",
				$time, m_tdata, m_tuser, m_tlast);
			mismatches++;
			return;
		end
		want = pending_replies.pop_front();
		results_seen++;
		compare_field("reply_kind",     want.reply_kind,     m_tdata[1:0]);
		compare_field("answered_count", want.answered_count, m_tdata[6:2]);
		compare_field("success_count",  want.success_count,  m_tdata[11:7]);
		compare_field("duplicate_seen", want.duplicate_seen, m_tuser[0]);
		compare_field("table_full",     want.table_full,     m_tuser[1]);
		compare_field("request_done",   want.request_done,   m_tlast);
		n_ack  += (want.reply_kind == REPLY_ACK);
		n_nak  += (want.reply_kind == REPLY_NAK);
		n_done += want.request_done;
		n_dup  += want.duplicate_seen;
		n_full += want.table_full;
	endtask

	initial begin
		int stall_left;
		int gap;
		stall_left = 0;
		forever begin
			@(posedge clk);
			if (arst_n && m_tvalid && m_tready)
				check_result();
			// one nonblocking update of ready per edge
			if (stall_left > 0) begin
				stall_left--;
				m_tready <= 1'b0;
			end else if (hold_request > 0) begin
				stall_left   = hold_request - 1;
				hold_request = 0;
				long_holds++;
				m_tready <= 1'b0;
			end else begin
				gap = pick_idle();
				if (gap > 0) begin
					stall_left = gap - 1;
					m_tready <= 1'b0;
				end else begin
					m_tready <= 1'b1;
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------

	// Reset values: quorum of one never replies, forward count 0 never closes
	task automatic test_reset_values();
		send_response(16'h1234, 1'b0);
		close_request();
	endtask

	// ACK with a repeated tag on the way, then NAK once failures pass the margin
	task automatic test_ack_and_nak();
		set_config(5'd3, 5'd3);
		send_response(16'h0000, 1'b0);
		send_response(16'h0000, 1'b1);     // repeat, ignored
		send_response(16'hFFFF, 1'b0);     // third success: ACK
		send_response(16'h00FF, 1'b1);     // last server, request closes
		set_config(5'd3, 5'd3);
		send_response(16'h0001, 1'b1);
		send_response(16'h0002, 1'b1);     // two failures over margin 1: NAK
		send_response(16'h0003, 1'b0);
	endtask

	// Quorum zero acks on a failure; quorum above the server total gives a
	// negative margin and NAKs on a success
	task automatic test_quorum_corners();
		set_config(5'd0, 5'd1);
		send_response(16'h8000, 1'b1);
		set_config(5'd17, 5'd1);
		send_response(16'h7FFF, 1'b0);
	endtask

	// Server total out of reach: table fills, next new tag is dropped
	task automatic test_table_full();
		set_config(5'd31, 5'd31);
		for (int k = 0; k <= MAX_SERVERS; k++)
			send_response(fresh_tag(), 1'(k % 3 == 0));
		close_request();
	endtask

	// Receiver holds off long while the sender keeps offering; input stalls
	task automatic test_output_holdoff();
		close_request();
		set_config(5'd9, 5'd12);
		idle_on      = 1'b0;
		hold_request = 300;
		run_request(12, 0);
		run_request(12, 20);
		idle_on      = 1'b1;
	endtask

	// Full-size requests with no gaps on either side
	task automatic test_back_to_back();
		idle_on = 1'b0;
		for (int k = 0; k < 3; k++) begin
			close_request();
			set_config(CFG_BITS'($urandom_range(2, 17)), 5'd16);
			run_request(16, 10);
		end
		idle_on = 1'b1;
	endtask

	// Random settings, mostly well-formed requests with random content;
	// some cut short (register change mid-request) or beyond table size
	task automatic test_random_requests(input int n_items);
		int base, q, f, n_new;
		base = new_tag_count;
		while (new_tag_count - base < n_items) begin
			if ($urandom_range(0, 99) < 75)
				close_request();
			case ($urandom_range(0, 9))
				0: f = 16;
				1: f = $urandom_range(17, 31);
				default: f = $urandom_range(0, 16);
			endcase
			case ($urandom_range(0, 9))
				0: q = 0;
				1: q = 1;
				2: q = 17;
				3: q = 31;
				default: q = $urandom_range(1, (f > 16) ? 17 : f + 2);
			endcase
			set_config(CFG_BITS'(q), CFG_BITS'(f));
			idle_on = ($urandom_range(0, 9) != 0);
			n_new   = f - rec_count;
			if (f <= MAX_SERVERS && n_new > 0 && $urandom_range(0, 99) < 80)
				run_request(n_new, 10);
			else
				run_request($urandom_range(1, 20), 30);
		end
		idle_on = 1'b1;
	endtask

	initial begin
		rec_count   = 0;
		rec_succ    = 0;
		reply_done  = 1'b0;
		quorum_reg  = 5'd1;
		forward_reg = 5'd0;
		arst_n = 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_values();
		test_ack_and_nak();
		test_quorum_corners();
		test_table_full();
		test_output_holdoff();
		test_back_to_back();
		test_random_requests(500);

		// settle: no more expectations, then a quiet stretch to catch strays
		drain_results();
		idle_on = 1'b0;
		repeat (40) @(posedge clk);

		$display("Run: %0d responses (%0d repeated tags, %0d on a full table), %0d register writes",
			sent_count, n_dup, n_full, cfg_writes);
		$display("Results: %0d checked, %0d ACK, %0d NAK, %0d requests closed, %0d long holdoffs",
			results_seen, n_ack, n_nak, n_done, long_holds);
		if (mismatches == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
